// ===== hdl/rmq_pkg.sv =====
// Shared constants, types and helpers for the rotation matrix to quaternion block.
package rmq_pkg;

	localparam int FRAC_BITS = 16;

	// Field widths of the ports.
	localparam int EW = 18;
	localparam int QW = 18;

	// Magnitude bits of an unnormalized component, and its signed width.
	localparam int AW = (FRAC_BITS > 17) ? FRAC_BITS + 2 : 19;
	localparam int VW = AW + 1;

	// Square, sum of squares, search remainder, running product, quotient.
	localparam int SQW = 2 * AW;
	localparam int SW  = SQW + 2;
	localparam int RW  = 2 * AW + 2 * FRAC_BITS + 8;
	localparam int PW  = SW + FRAC_BITS + 4;
	localparam int QMW = FRAC_BITS + 1;

	// Search stages: one per result bit.
	localparam int NSRCH = FRAC_BITS + 1;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic signed [QW-1:0] OUT_MAX_C = {1'b0, {(QW - 1){1'b1}}};
	localparam logic signed [QW-1:0] OUT_MIN_C = {1'b1, {(QW - 1){1'b0}}};
	localparam logic signed [VW-1:0] ONE_V =
		{{(VW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [QMW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

	// One classified item: unnormalized x, y, z, w in slots 0 to 3.
	typedef struct packed {
		logic [3:0][VW-1:0] vec;
		branch_t            br;
		logic               degen;
	} item_t;

	// Side information that travels with an item through the back end.
	typedef struct packed {
		branch_t    br;
		logic       degen;
		logic [3:0] neg;
	} meta_t;

	// Applies the sign to a rounded magnitude and clamps to the port range.
	function automatic logic signed [QW-1:0] sat_out(input logic [QMW-1:0] m,
			input logic neg);
		logic [QMW+QW-1:0] mw;
		logic signed [QW-1:0] r;
		mw = (QMW + QW)'(m);
		if (neg) begin
			if (mw > (QMW + QW)'(2 ** (QW - 1)))
				r = OUT_MIN_C;
			else
				r = -$signed(mw[QW-1:0]);
		end else begin
			if (mw > (QMW + QW)'(OUT_MAX_C))
				r = OUT_MAX_C;
			else
				r = $signed(mw[QW-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== hdl/rmq_front.sv =====
// Front end: takes a matrix beat, picks the branch and forms the unnormalized quaternion.
module rmq_front import rmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [EW-1:0] elem_r0c0,
	input  logic signed [EW-1:0] elem_r0c1,
	input  logic signed [EW-1:0] elem_r0c2,
	input  logic signed [EW-1:0] elem_r1c0,
	input  logic signed [EW-1:0] elem_r1c1,
	input  logic signed [EW-1:0] elem_r1c2,
	input  logic signed [EW-1:0] elem_r2c0,
	input  logic signed [EW-1:0] elem_r2c1,
	input  logic signed [EW-1:0] elem_r2c2,
	output logic                 push_valid,
	input  logic                 push_ready,
	output item_t                push_item
);

	logic signed [VW-1:0] e [9];
	logic signed [VW-1:0] trace, dmax, vi;
	logic                 sel_y, sel_z;
	item_t                cls;
	item_t                item_s1;
	logic                 vld_s1;

	assign e[0] = VW'(elem_r0c0);
	assign e[1] = VW'(elem_r0c1);
	assign e[2] = VW'(elem_r0c2);
	assign e[3] = VW'(elem_r1c0);
	assign e[4] = VW'(elem_r1c1);
	assign e[5] = VW'(elem_r1c2);
	assign e[6] = VW'(elem_r2c0);
	assign e[7] = VW'(elem_r2c1);
	assign e[8] = VW'(elem_r2c2);

	always_comb begin
		trace = e[0] + e[4] + e[8];
		sel_y = e[4] > e[0];
		dmax  = sel_y ? e[4] : e[0];
		sel_z = e[8] > dmax;
		vi    = '0;
		cls   = '0;
		if (trace > 0) begin
			cls.br     = BR_TRACE;
			cls.vec[0] = e[5] - e[7];
			cls.vec[1] = e[6] - e[2];
			cls.vec[2] = e[1] - e[3];
			cls.vec[3] = trace + ONE_V;
		end else begin
			case ({sel_z, sel_y})
				2'b00: begin
					cls.br     = BR_X;
					vi         = e[0] - (e[4] + e[8]) + ONE_V;
					cls.vec[0] = vi;
					cls.vec[1] = e[1] + e[3];
					cls.vec[2] = e[2] + e[6];
					cls.vec[3] = e[5] - e[7];
				end
				2'b01: begin
					cls.br     = BR_Y;
					vi         = e[4] - (e[8] + e[0]) + ONE_V;
					cls.vec[1] = vi;
					cls.vec[2] = e[5] + e[7];
					cls.vec[0] = e[3] + e[1];
					cls.vec[3] = e[6] - e[2];
				end
				default: begin
					cls.br     = BR_Z;
					vi         = e[8] - (e[0] + e[4]) + ONE_V;
					cls.vec[2] = vi;
					cls.vec[0] = e[6] + e[2];
					cls.vec[1] = e[7] + e[5];
					cls.vec[3] = e[1] - e[3];
				end
			endcase
			// A root that would not be positive forces the identity.
			cls.degen = (vi <= 0);
		end
	end

	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= cls;
	end

endmodule

// ===== hdl/rmq_queue.sv =====
// Short queue of classified items between the front and back ends.
module rmq_queue import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t            slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             push, pop;

	assign push_ready = (count_q != QCW'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

// ===== hdl/rmq_back.sv =====
// Back end: sum of squares, bitwise rounding search for each component, saturation.
module rmq_back import rmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  item_t                pop_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [QW-1:0] quat_x,
	output logic signed [QW-1:0] quat_y,
	output logic signed [QW-1:0] quat_z,
	output logic signed [QW-1:0] quat_w,
	output logic [1:0]           branch_taken,
	output logic                 degenerate
);

	logic                 en;

	logic                 vld_s1, vld_s2;
	meta_t                meta_s1, meta_s2;
	logic [AW-1:0]        mag_s1 [4];
	logic [SQW-1:0]       sq_s2 [4];

	// Search pipeline; entry 0 is loaded from the squares, entry n+1 after bit n.
	logic                 vld_s3  [NSRCH+1];
	meta_t                meta_s3 [NSRCH+1];
	logic [SW-1:0]        sum_s3  [NSRCH+1];
	logic signed [RW-1:0] rem_s3  [NSRCH+1][4];
	logic signed [PW-1:0] pacc_s3 [NSRCH+1][4];
	logic [QMW-1:0]       qv_s3   [NSRCH+1][4];

	logic signed [RW-1:0] trial [NSRCH][4];
	logic [SW-1:0]        sum_c;

	logic                 out_vld_q;
	meta_t                meta_q;
	logic signed [QW-1:0] quat_q [4];

	assign en        = !out_vld_q || out_ready;
	assign pop_ready = en;

	// Stage 1: magnitudes and signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1.br    <= pop_item.br;
			meta_s1.degen <= pop_item.degen;
			for (int c = 0; c < 4; c++) begin
				meta_s1.neg[c] <= pop_item.vec[c][VW-1];
				mag_s1[c] <= pop_item.vec[c][VW-1] ? AW'(-$signed(pop_item.vec[c]))
				                                   : AW'(pop_item.vec[c]);
			end
			// Stage 2: squares.
			meta_s2 <= meta_s1;
			for (int c = 0; c < 4; c++)
				sq_s2[c] <= SQW'(mag_s1[c]) * SQW'(mag_s1[c]);
		end
	end

	assign sum_c = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]) + SW'(sq_s2[3]);

	// Each search step tries to set bit B of the result. The remainder holds
	// 4*a^2*2^(2F) - (2q-1)^2*S and the running product holds (2q-1)*S, so the
	// trial subtracts (2^(B+2))*(2q-1)*S + 2^(2B+2)*S.
	always_comb begin
		for (int n = 0; n < NSRCH; n++) begin
			for (int c = 0; c < 4; c++) begin
				trial[n][c] = rem_s3[n][c]
					- ((RW'(pacc_s3[n][c]) <<< (FRAC_BITS - n + 2))
					+ (RW'(sum_s3[n]) << (2 * (FRAC_BITS - n) + 2)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n <= NSRCH; n++)
				vld_s3[n] <= 1'b0;
		end else if (en) begin
			vld_s3[0] <= vld_s2;
			for (int n = 0; n < NSRCH; n++)
				vld_s3[n+1] <= vld_s3[n];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 3: sum of squares and search start.
			meta_s3[0].br    <= meta_s2.br;
			meta_s3[0].neg   <= meta_s2.neg;
			meta_s3[0].degen <= meta_s2.degen || (sum_c == '0);
			sum_s3[0]        <= sum_c;
			for (int c = 0; c < 4; c++) begin
				rem_s3[0][c]  <= (RW'(sq_s2[c]) << (2 * FRAC_BITS + 2)) - RW'(sum_c);
				pacc_s3[0][c] <= -PW'(sum_c);
				qv_s3[0][c]   <= '0;
			end
			for (int n = 0; n < NSRCH; n++) begin
				meta_s3[n+1] <= meta_s3[n];
				sum_s3[n+1]  <= sum_s3[n];
				for (int c = 0; c < 4; c++) begin
					if (!trial[n][c][RW-1]) begin
						rem_s3[n+1][c]  <= trial[n][c];
						pacc_s3[n+1][c] <= pacc_s3[n][c]
							+ (PW'(sum_s3[n]) << (FRAC_BITS - n + 1));
						qv_s3[n+1][c]   <= qv_s3[n][c] | (ONE_Q >> n);
					end else begin
						rem_s3[n+1][c]  <= rem_s3[n][c];
						pacc_s3[n+1][c] <= pacc_s3[n][c];
						qv_s3[n+1][c]   <= qv_s3[n][c];
					end
				end
			end
		end
	end

	// Output register: sign, clamp, identity on a degenerate item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_s3[NSRCH];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q <= meta_s3[NSRCH];
			for (int c = 0; c < 3; c++)
				quat_q[c] <= meta_s3[NSRCH].degen ? '0
				           : sat_out(qv_s3[NSRCH][c], meta_s3[NSRCH].neg[c]);
			quat_q[3] <= meta_s3[NSRCH].degen ? sat_out(ONE_Q, 1'b0)
			           : sat_out(qv_s3[NSRCH][3], meta_s3[NSRCH].neg[3]);
		end
	end

	assign out_valid    = out_vld_q;
	assign quat_x       = quat_q[0];
	assign quat_y       = quat_q[1];
	assign quat_z       = quat_q[2];
	assign quat_w       = quat_q[3];
	assign branch_taken = meta_q.br;
	assign degenerate   = meta_q.degen;

	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && meta_q.degen) |-> (quat_q[0] == '0 && quat_q[1] == '0
			&& quat_q[2] == '0 && quat_q[3] == sat_out(ONE_Q, 1'b0)))
		else $error("degenerate result is not the identity");

	a_trace_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && meta_q.br == BR_TRACE) |-> !meta_q.degen)
		else $error("trace branch flagged degenerate");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3[NSRCH] && !en) |=> vld_s3[NSRCH])
		else $error("search pipeline dropped an item while stalled");

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to unit quaternion converter.
// This block takes one 3x3 matrix per beat, elements signed with FRAC_BITS fraction
// bits, and returns the unit quaternion (x, y, z, w) in the same format, together
// with the branch used (0 for the trace branch, 1 to 3 for the diagonal branch on
// x, y or z) and a flag that is set when the identity was forced because a root
// was not positive or the length came out zero. Results saturate to the 18-bit
// range, so with more than 16 fraction bits a component of magnitude one reads as
// the port limit. The block accepts a new matrix every cycle and delivers one
// result per cycle when the output side keeps up. When nothing stalls, the
// classifier registers an accepted beat, the queue takes it, and it then passes
// the magnitude, square and sum of squares registers, the rounding search and
// the output register. The four-entry queue lets the classifier keep taking
// beats while the output is held, until the queue is full.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [EW-1:0] elem_r0c0,
	input  logic signed [EW-1:0] elem_r0c1,
	input  logic signed [EW-1:0] elem_r0c2,
	input  logic signed [EW-1:0] elem_r1c0,
	input  logic signed [EW-1:0] elem_r1c1,
	input  logic signed [EW-1:0] elem_r1c2,
	input  logic signed [EW-1:0] elem_r2c0,
	input  logic signed [EW-1:0] elem_r2c1,
	input  logic signed [EW-1:0] elem_r2c2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [QW-1:0] quat_x,
	output logic signed [QW-1:0] quat_y,
	output logic signed [QW-1:0] quat_z,
	output logic signed [QW-1:0] quat_w,
	output logic [1:0]           branch_taken,
	output logic                 degenerate
);

	// Classified items flow from the front end into the queue, and from the
	// queue into the normalization back end.
	logic  push_valid, push_ready;
	item_t push_item;
	logic  pop_valid, pop_ready;
	item_t pop_item;

	rmq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.elem_r0c0  (elem_r0c0),
		.elem_r0c1  (elem_r0c1),
		.elem_r0c2  (elem_r0c2),
		.elem_r1c0  (elem_r1c0),
		.elem_r1c1  (elem_r1c1),
		.elem_r1c2  (elem_r1c2),
		.elem_r2c0  (elem_r2c0),
		.elem_r2c1  (elem_r2c1),
		.elem_r2c2  (elem_r2c2),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	rmq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// The back end advances as a whole whenever its output register is empty
	// or being emptied, so a held result stalls every stage behind it.
	rmq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.quat_w       (quat_w),
		.branch_taken (branch_taken),
		.degenerate   (degenerate)
	);

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 100ps

module tb;
	import rmq_pkg::*;

	localparam int N_RANDOM   = 1030;
	localparam int QUIET_TAIL = 120;
	localparam int WATCHDOG   = 4000;
	localparam longint ONE_L  = longint'(1) << FRAC_BITS;

	typedef logic [8:0][EW-1:0] matrix_t;

	// One result beat as seen on the output ports.
	typedef struct packed {
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [QW-1:0] qz;
		logic [QW-1:0] qw;
		branch_t       br;
		logic          degen;
	} quat_t;

	// One row of the directed table. Where known is set, the quaternion is typed in.
	typedef struct {
		matrix_t mx;
		logic    known;
		quat_t   res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0] branch_taken;
	logic degenerate;

	quat_t quat_pending[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0;

	always #5 clk = ~clk;

	rotation_matrix_to_quaternion u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.elem_r0c0(e00), .elem_r0c1(e01), .elem_r0c2(e02),
		.elem_r1c0(e10), .elem_r1c1(e11), .elem_r1c2(e12),
		.elem_r2c0(e20), .elem_r2c1(e21), .elem_r2c2(e22),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.branch_taken(branch_taken), .degenerate(degenerate)
	);

	// Rounded normalization: sign(v) * floor(|v| * 2^F / sqrt(s) + 1/2), found by
	// a bit-by-bit search that compares squares exactly, so no root is taken.
	function automatic longint norm_round(input longint v, input logic [127:0] s);
		logic [127:0] mg, rhs, cand, d;
		longint q;
		mg = (v < 0) ? 128'(-v) : 128'(v);
		rhs = (mg * mg) << (2 * FRAC_BITS + 2);
		q = 0;
		for (int b = FRAC_BITS; b >= 0; b--) begin
			cand = 128'(q | (longint'(1) << b));
			d = 2 * cand - 1;
			if (d * d * s <= rhs)
				q = longint'(cand);
		end
		return (v < 0) ? -q : q;
	endfunction

	function automatic logic [QW-1:0] clamp_q(input longint v);
		if (v > 131071)
			v = 131071;
		if (v < -131072)
			v = -131072;
		return QW'(v);
	endfunction

	function automatic quat_t predict_quat(input matrix_t mx);
		longint m[3][3];
		longint q[4];
		longint tr;
		logic [127:0] s;
		int i, j, k;
		quat_t r;
		for (int a = 0; a < 9; a++)
			m[a / 3][a % 3] = longint'($signed(mx[a]));
		r.degen = 1'b0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			r.br = BR_TRACE;
			q[0] = m[1][2] - m[2][1];
			q[1] = m[2][0] - m[0][2];
			q[2] = m[0][1] - m[1][0];
			q[3] = tr + ONE_L;
		end else begin
			// Largest diagonal element picks the axis; a tie keeps the lower one.
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			r.br = branch_t'(i + 1);
			q[i] = m[i][i] - (m[j][j] + m[k][k]) + ONE_L;
			q[j] = m[i][j] + m[j][i];
			q[k] = m[i][k] + m[k][i];
			q[3] = m[j][k] - m[k][j];
			if (q[i] <= 0)
				r.degen = 1'b1;
		end
		s = 0;
		for (int a = 0; a < 4; a++)
			s += 128'(q[a] * q[a]);
		if (s == 0)
			r.degen = 1'b1;
		if (r.degen) begin
			q[0] = 0; q[1] = 0; q[2] = 0; q[3] = ONE_L;
		end else begin
			for (int a = 0; a < 4; a++)
				q[a] = norm_round(q[a], s);
		end
		r.qx = clamp_q(q[0]);
		r.qy = clamp_q(q[1]);
		r.qz = clamp_q(q[2]);
		r.qw = clamp_q(q[3]);
		return r;
	endfunction

	function automatic matrix_t diag_mx(input longint a, input longint b, input longint c);
		matrix_t mx;
		mx = '0;
		mx[0] = EW'(a);
		mx[4] = EW'(b);
		mx[8] = EW'(c);
		return mx;
	endfunction

	// A random signed permutation matrix with small noise on every element, so
	// that all four branches see plausible rotations.
	function automatic matrix_t near_rotation();
		matrix_t mx;
		int perm[3];
		int p, t;
		perm = '{0, 1, 2};
		for (int a = 2; a > 0; a--) begin
			p = $urandom_range(a, 0);
			t = perm[a]; perm[a] = perm[p]; perm[p] = t;
		end
		for (int a = 0; a < 9; a++)
			mx[a] = EW'(int'($urandom_range(4096, 0)) - 2048);
		for (int r = 0; r < 3; r++)
			mx[r * 3 + perm[r]] = EW'(($urandom_range(1, 0) ? 1 : -1) * int'(ONE_L)
				+ int'($urandom_range(2048, 0)) - 1024);
		return mx;
	endfunction

	function automatic matrix_t random_mx();
		matrix_t mx;
		case ($urandom_range(3, 0))
			0: for (int a = 0; a < 9; a++) mx[a] = EW'($urandom);
			1: for (int a = 0; a < 9; a++)
				mx[a] = EW'(int'($urandom_range(2 * ONE_L, 0)) - int'(ONE_L));
			default: mx = near_rotation();
		endcase
		return mx;
	endfunction

	// Input side: every accepted beat gets its expectation queued at once.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			quat_pending.push_back(predict_quat({e22, e21, e20, e12, e11, e10, e02, e01, e00}));
	end

	// Output side: compare each accepted beat against the oldest expectation.
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (quat_pending.size() == 0) begin
				$display("%0t: unexpected result beat x=%0d", $time, quat_x);
				errors++;
			end else begin
				want = quat_pending.pop_front();
				if (quat_x !== want.qx) begin
					$display("%0t: quat_x exp %0d got %0d", $time, $signed(want.qx), quat_x);
					errors++;
				end
				if (quat_y !== want.qy) begin
					$display("%0t: quat_y exp %0d got %0d", $time, $signed(want.qy), quat_y);
					errors++;
				end
				if (quat_z !== want.qz) begin
					$display("%0t: quat_z exp %0d got %0d", $time, $signed(want.qz), quat_z);
					errors++;
				end
				if (quat_w !== want.qw) begin
					$display("%0t: quat_w exp %0d got %0d", $time, $signed(want.qw), quat_w);
					errors++;
				end
				if (branch_taken !== want.br) begin
					$display("%0t: branch_taken exp %0d got %0d", $time, want.br, branch_taken);
					errors++;
				end
				if (degenerate !== want.degen) begin
					$display("%0t: degenerate exp %0d got %0d", $time, want.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: stalls in random bursts until the quiet tail of the run.
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(3, 0) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(14, 1)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	// Presents one beat and holds it until the block takes it. A random gap may
	// come first; valid is only lowered when a gap is inserted.
	task automatic send_matrix(input matrix_t mx);
		if (!quiet && $urandom_range(4, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{e22, e21, e20, e12, e11, e10, e02, e01, e00} <= mx;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{e22, e21, e20, e12, e11, e10, e02, e01, e00} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Identity and the half turns have an obvious answer.
		rw.known = 1'b1;
		rw.mx = diag_mx(ONE_L, ONE_L, ONE_L);
		rw.res = '{qx: 0, qy: 0, qz: 0, qw: QW'(ONE_L), br: BR_TRACE, degen: 1'b0};
		rows.push_back(rw);
		// The zero matrix has a zero trace, so it falls to the x axis on a tie.
		rw.mx = '0;
		rw.res = '{qx: QW'(ONE_L), qy: 0, qz: 0, qw: 0, br: BR_X, degen: 1'b0};
		rows.push_back(rw);
		rw.mx = diag_mx(ONE_L, -ONE_L, -ONE_L);
		rows.push_back(rw);
		rw.mx = diag_mx(-ONE_L, ONE_L, -ONE_L);
		rw.res = '{qx: 0, qy: QW'(ONE_L), qz: 0, qw: 0, br: BR_Y, degen: 1'b0};
		rows.push_back(rw);
		rw.mx = diag_mx(-ONE_L, -ONE_L, ONE_L);
		rw.res = '{qx: 0, qy: 0, qz: QW'(ONE_L), qw: 0, br: BR_Z, degen: 1'b0};
		rows.push_back(rw);
		// Field extremes, ties on the diagonal and a few quarter turns.
		rw.known = 1'b0;
		rw.mx = {9{EW'(131071)}};                     rows.push_back(rw);
		rw.mx = {9{EW'(-131072)}};                    rows.push_back(rw);
		rw.mx = {9{EW'(-1)}};                         rows.push_back(rw);
		rw.mx = {9{EW'(1)}};                          rows.push_back(rw);
		rw.mx = diag_mx(-131072, -131072, -131072);   rows.push_back(rw);
		rw.mx = diag_mx(-5, -5, -7);                  rows.push_back(rw);
		rw.mx = diag_mx(-7, -5, -5);                  rows.push_back(rw);
		rw.mx = diag_mx(131071, -131072, -131072);    rows.push_back(rw);
		rw.mx = {EW'(131071), EW'(-131072), EW'(131071), EW'(-131072), EW'(0),
			EW'(131071), EW'(-131072), EW'(131071), EW'(-131072)};
		rows.push_back(rw);
		rw.mx = {EW'(ONE_L), EW'(0), EW'(0), EW'(0), EW'(0), EW'(-ONE_L),
			EW'(0), EW'(ONE_L), EW'(0)};
		rows.push_back(rw);
		rw.mx = {EW'(0), EW'(0), EW'(ONE_L), EW'(0), EW'(ONE_L), EW'(0),
			EW'(-ONE_L), EW'(0), EW'(0)};
		rows.push_back(rw);
		rw.mx = {EW'(0), EW'(-ONE_L), EW'(0), EW'(ONE_L), EW'(0), EW'(0),
			EW'(0), EW'(0), EW'(ONE_L)};
		rows.push_back(rw);

		foreach (rows[n]) begin
			send_matrix(rows[n].mx);
			// A typed answer must agree with the predictor's own.
			if (rows[n].known && predict_quat(rows[n].mx) !== rows[n].res) begin
				$display("%0t: directed row %0d exp %h got %h", $time, n,
					rows[n].res, predict_quat(rows[n].mx));
				errors++;
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - QUIET_TAIL)
				quiet = 1;
			send_matrix(random_mx());
		end
		in_valid <= 1'b0;

		waited = 0;
		while (quat_pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * FRAC_BITS + 20) @(posedge clk);
		if (errors == 0 && quat_pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
